>>> sv/fthd_pkg.sv
// Shared types, codes and helpers for the file transfer header deframer.
`default_nettype none

package fthd_pkg;

    localparam int unsigned LENGTH_BITS_DEF = 32;
    localparam int unsigned NAME_LEFT_W     = 16;
    localparam int unsigned MAX_LEN_W       = 16;
    localparam int unsigned WIDE_W          = 32;

    localparam logic [MAX_LEN_W-1:0] MAX_NAME_LEN_RST = 16'd4096;

    // parser phases
    localparam logic [2:0] PH_NAME_LEN = 3'd0;
    localparam logic [2:0] PH_FILE_LEN = 3'd1;
    localparam logic [2:0] PH_NAME     = 3'd2;
    localparam logic [2:0] PH_DATA     = 3'd3;
    localparam logic [2:0] PH_DONE     = 3'd4;
    localparam logic [2:0] PH_ERROR    = 3'd5;

    // byte kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_NAME = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;

    // reported status
    localparam logic [2:0] ST_HEADER = 3'd0;
    localparam logic [2:0] ST_NAME   = 3'd1;
    localparam logic [2:0] ST_DATA   = 3'd2;
    localparam logic [2:0] ST_DONE   = 3'd3;
    localparam logic [2:0] ST_ERROR  = 3'd4;

    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;
    localparam logic [7:0] CHAR_LOW   = 8'h20;
    localparam logic [7:0] CHAR_HIGH  = 8'h7E;

    localparam logic [1:0] HDR_LAST = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] byte_kind;
        logic       last_data;
        logic [2:0] phase_status;
    } out_item_t;

    typedef struct packed {
        logic [2:0] phase;
        logic [1:0] hdr_cnt;
    } ctrl_t;

    function automatic logic [2:0] status_of(input logic [2:0] ph);
        logic [2:0] st;
        case (ph)
            PH_NAME:  st = ST_NAME;
            PH_DATA:  st = ST_DATA;
            PH_DONE:  st = ST_DONE;
            PH_ERROR: st = ST_ERROR;
            default:  st = ST_HEADER;
        endcase
        return st;
    endfunction

    function automatic logic [7:0] sanitize(input logic [7:0] b);
        logic [7:0] r;
        if (b >= CHAR_LOW && b <= CHAR_HIGH && b != CHAR_SLASH)
            r = b;
        else
            r = CHAR_UNDER;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/fthd_step.sv
// Combinational parser step: next parser state and the result for one byte.
`default_nettype none

module fthd_step #(
    parameter int unsigned LENGTH_BITS = fthd_pkg::LENGTH_BITS_DEF
) (
    input  fthd_pkg::ctrl_t                     ctrl,
    input  logic [LENGTH_BITS-1:0]              acc,
    input  logic [fthd_pkg::NAME_LEFT_W-1:0]    name_left,
    input  logic [LENGTH_BITS-1:0]              file_left,
    input  logic [fthd_pkg::MAX_LEN_W-1:0]      max_len,
    input  fthd_pkg::in_item_t                  item,
    output fthd_pkg::ctrl_t                     ctrl_next,
    output logic [LENGTH_BITS-1:0]              acc_next,
    output logic [fthd_pkg::NAME_LEFT_W-1:0]    name_left_next,
    output logic [LENGTH_BITS-1:0]              file_left_next,
    output fthd_pkg::out_item_t                 result
);
    import fthd_pkg::*;

    ctrl_t                  cur_ctrl;
    logic [LENGTH_BITS-1:0] cur_acc;
    logic [NAME_LEFT_W-1:0] cur_name_left;
    logic [LENGTH_BITS-1:0] cur_file_left;
    logic [WIDE_W-1:0]      acc_wide;
    logic [LENGTH_BITS-1:0] asm_len;
    logic                   hdr_done;
    logic [NAME_LEFT_W-1:0] name_dec;
    logic [LENGTH_BITS-1:0] file_dec;

    always_comb
    begin
        // restart clears the parser before this byte is taken
        if (item.restart)
        begin
            cur_ctrl      = '{phase: PH_NAME_LEN, hdr_cnt: '0};
            cur_acc       = '0;
            cur_name_left = '0;
            cur_file_left = '0;
        end
        else
        begin
            cur_ctrl      = ctrl;
            cur_acc       = acc;
            cur_name_left = name_left;
            cur_file_left = file_left;
        end

        acc_wide = WIDE_W'(cur_acc)
                 | (WIDE_W'(item.data_byte) << {cur_ctrl.hdr_cnt, 3'b000});
        asm_len  = acc_wide[LENGTH_BITS-1:0];
        hdr_done = (cur_ctrl.hdr_cnt == HDR_LAST);
        name_dec = (cur_name_left != '0) ? cur_name_left - 1'b1 : cur_name_left;
        file_dec = (cur_file_left != '0) ? cur_file_left - 1'b1 : cur_file_left;

        ctrl_next      = cur_ctrl;
        acc_next       = cur_acc;
        name_left_next = cur_name_left;
        file_left_next = cur_file_left;
        result.out_byte  = '0;
        result.byte_kind = KIND_NONE;
        result.last_data = 1'b0;

        case (cur_ctrl.phase)
            PH_NAME_LEN:
            begin
                ctrl_next.hdr_cnt = cur_ctrl.hdr_cnt + 1'b1;
                acc_next          = asm_len;
                if (hdr_done)
                begin
                    acc_next = '0;
                    if (asm_len == '0 || WIDE_W'(asm_len) > WIDE_W'(max_len))
                        ctrl_next.phase = PH_ERROR;
                    else
                    begin
                        name_left_next  = NAME_LEFT_W'(asm_len);
                        ctrl_next.phase = PH_FILE_LEN;
                    end
                end
            end
            PH_FILE_LEN:
            begin
                ctrl_next.hdr_cnt = cur_ctrl.hdr_cnt + 1'b1;
                acc_next          = asm_len;
                if (hdr_done)
                begin
                    acc_next       = '0;
                    file_left_next = asm_len;
                    if (cur_name_left != '0)
                        ctrl_next.phase = PH_NAME;
                    else if (asm_len != '0)
                        ctrl_next.phase = PH_DATA;
                    else
                        ctrl_next.phase = PH_DONE;
                end
            end
            PH_NAME:
            begin
                result.byte_kind = KIND_NAME;
                result.out_byte  = sanitize(item.data_byte);
                name_left_next   = name_dec;
                if (name_dec == '0)
                    ctrl_next.phase = (cur_file_left != '0) ? PH_DATA : PH_DONE;
            end
            PH_DATA:
            begin
                result.byte_kind = KIND_DATA;
                result.out_byte  = item.data_byte;
                file_left_next   = file_dec;
                if (file_dec == '0)
                begin
                    result.last_data = 1'b1;
                    ctrl_next.phase  = PH_DONE;
                end
            end
            default:
            begin
                // complete or error: byte ignored
            end
        endcase

        result.phase_status = status_of(ctrl_next.phase);
    end

endmodule

`default_nettype wire

>>> sv/fthd_obuf.sv
// Two-entry output buffer: result register plus skid register.
`default_nettype none

module fthd_obuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fthd_pkg::out_item_t push_data,
    output logic                full,
    output logic                out_valid,
    input  logic                out_stall,
    output fthd_pkg::out_item_t out_data
);
    import fthd_pkg::*;

    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t main_data_reg, main_data_next;
    out_item_t skid_data_reg, skid_data_next;
    logic      pop;

    assign pop       = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // no push possible while full
            if (pop)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_data_next  = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
            main_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

>>> sv/file_transfer_header_deframer.sv
// Top level of the file transfer header deframer.
//
//  channel | direction | payload              | handshake
//  --------+-----------+----------------------+--------------------------
//  in      | input     | in_item_t  in_data   | in_valid  / in_stall
//  out     | output    | out_item_t out_data  | out_valid / out_stall
//  cfg     | input     | max_name_length      | cfg_we (no wait)
//
// One byte per cycle unless stalled; each result is registered in fthd_obuf.
// The parser step is one pass of counter updates and compares on registered state.
// in_stall rises only when both output registers hold results (skid full).
// Reset clears parser state and sets max_name_length to 4096.
`default_nettype none

module file_transfer_header_deframer #(
    parameter int unsigned LENGTH_BITS = fthd_pkg::LENGTH_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  fthd_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output fthd_pkg::out_item_t               out_data,
    input  logic                              cfg_we,
    input  logic [fthd_pkg::MAX_LEN_W-1:0]    cfg_data
);
    import fthd_pkg::*;

    ctrl_t                  ctrl_reg, ctrl_next;
    logic [LENGTH_BITS-1:0] acc_reg, acc_next;
    logic [NAME_LEFT_W-1:0] name_left_reg, name_left_next;
    logic [LENGTH_BITS-1:0] file_left_reg, file_left_next;
    logic [MAX_LEN_W-1:0]   max_len_reg;
    out_item_t              result;
    logic                   full;
    logic                   accept;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    fthd_step #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .ctrl           (ctrl_reg),
        .acc            (acc_reg),
        .name_left      (name_left_reg),
        .file_left      (file_left_reg),
        .max_len        (max_len_reg),
        .item           (in_data),
        .ctrl_next      (ctrl_next),
        .acc_next       (acc_next),
        .name_left_next (name_left_next),
        .file_left_next (file_left_next),
        .result         (result)
    );

    fthd_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg      <= '{phase: PH_NAME_LEN, hdr_cnt: '0};
            acc_reg       <= '0;
            name_left_reg <= '0;
            file_left_reg <= '0;
            max_len_reg   <= MAX_NAME_LEN_RST;
        end
        else
        begin
            if (accept)
            begin
                ctrl_reg      <= ctrl_next;
                acc_reg       <= acc_next;
                name_left_reg <= name_left_next;
                file_left_reg <= file_left_next;
            end
            if (cfg_we)
                max_len_reg <= cfg_data;
        end
    end

endmodule

`default_nettype wire
